@@ rtl/ccsu_pkg.sv @@
package ccsu_pkg;

  // Request codes
  localparam logic [3:0] REQ_CHECK_IN    = 4'd0;
  localparam logic [3:0] REQ_CHECK_OUT   = 4'd1;
  localparam logic [3:0] REQ_LOCK_DOOR   = 4'd2;
  localparam logic [3:0] REQ_GET_COUNT   = 4'd3;
  localparam logic [3:0] REQ_RESET       = 4'd4;
  localparam logic [3:0] REQ_RELEASE_AP  = 4'd5;
  localparam logic [3:0] REQ_AP_WAIT     = 4'd6;
  localparam logic [3:0] REQ_RELEASE_BSP = 4'd7;
  localparam logic [3:0] REQ_BSP_WAIT    = 4'd8;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABORTED = 3'd1;
  localparam logic [2:0] ST_BLOCK   = 3'd2;
  localparam logic [2:0] ST_BADIDX  = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  localparam logic [6:0] ACTIVE_CPUS_RST = 7'd64;
  localparam logic [6:0] ARRIVAL_MAX     = 7'd127;
  localparam logic [7:0] SEM_MAX         = 8'd255;

  typedef struct packed {
    logic [3:0] req_type;
    logic [5:0] cpu_index;
    logic [5:0] bsp_index;
    logic [5:0] ap_count;
  } ccsu_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] count;
  } ccsu_out_t;

endpackage

@@ rtl/ccsu_ram.sv @@
module ccsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/cpu_checkin_semaphore_unit.sv @@
// Processor rendezvous unit. Each request transfer on the in_ channel yields exactly one
// result transfer on the out_ channel, in order. The arrival count, door lock and the count
// recorded at lock time sit in flip-flops; the per-processor run semaphores sit in a
// synchronous RAM of MAX_CPUS bytes. A request reads its semaphore entry at the edge it is
// accepted; the stage after the RAM then decides the outcome and, as it retires, writes the
// entry back and loads the output register. The unit takes one request per cycle while
// results are taken. The throughput is set by the single RAM read-modify-write: a
// write-back that coincides with the read of the next request is forwarded to it. The
// semaphores clear at reset through a valid bit per entry, so no clearing pass is needed.
// active_cpus may only be written while no request is in flight.
module cpu_checkin_semaphore_unit #(
  parameter int MAX_CPUS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccsu_pkg::ccsu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ccsu_pkg::ccsu_out_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  import ccsu_pkg::*;

  localparam int AW = $clog2(MAX_CPUS);
  localparam logic [8:0] MAX_CPUS_W = 9'(MAX_CPUS);

  // Turns a six-bit processor index into a RAM address of the width the depth needs.
  function automatic logic [AW-1:0] to_addr(input logic [5:0] idx);
    logic [7:0] ext;
    ext = {2'b00, idx};
    return ext[AW-1:0];
  endfunction

  // Semaphore entry that a request touches: the application processor for release ap and
  // ap wait, the boot processor otherwise.
  function automatic logic [AW-1:0] sem_addr(input ccsu_in_t req);
    logic [AW-1:0] a;
    a = (req.req_type == REQ_RELEASE_AP || req.req_type == REQ_AP_WAIT) ?
        to_addr(req.cpu_index) : to_addr(req.bsp_index);
    return a;
  endfunction

  // Configuration and rendezvous state
  logic [6:0]          active_r;
  logic [6:0]          arrival_r,  arrival_nxt;
  logic                locked_r,   locked_nxt;
  logic [6:0]          cal_r,      cal_nxt;
  logic [MAX_CPUS-1:0] sem_vld_r;

  // Stage after the RAM read
  logic                s1_vld_r,   s1_vld_nxt;
  ccsu_in_t            s1_req_r;
  logic                s1_fwd_r;
  logic [7:0]          s1_fwd_data_r;

  // Output register
  logic                out_vld_r,  out_vld_nxt;
  ccsu_out_t           out_data_r, out_data_nxt;

  // RAM port signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  logic                in_acc;
  logic                s1_fire;
  logic [AW-1:0]       s1_addr;
  logic [7:0]          sem_cur;
  logic                cpu_ok;
  logic                bsp_ok;
  logic                pair_ok;
  logic                aps_ok;

  // Handshake: stage 1 retires whenever the output register is empty or being emptied,
  // and a new request may enter in the same cycle.
  assign s1_fire  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  assign ram_re    = in_acc;
  assign ram_raddr = sem_addr(in_data);
  assign s1_addr   = sem_addr(s1_req_r);

  ccsu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CPUS)
  ) u_sem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Current semaphore value. An entry never written since reset reads as zero; a
  // write-back at the very edge this request read the RAM is taken from the forward
  // register, since the RAM returned the older word.
  always_comb begin
    if (!sem_vld_r[s1_addr]) begin
      sem_cur = 8'd0;
    end else if (s1_fwd_r) begin
      sem_cur = s1_fwd_data_r;
    end else begin
      sem_cur = ram_rdata;
    end
  end

  // An index is valid only below both active_cpus and the size of the semaphore array.
  assign cpu_ok  = ({1'b0, s1_req_r.cpu_index} < active_r) &&
                   ({3'b000, s1_req_r.cpu_index} < MAX_CPUS_W);
  assign bsp_ok  = ({1'b0, s1_req_r.bsp_index} < active_r) &&
                   ({3'b000, s1_req_r.bsp_index} < MAX_CPUS_W);
  assign pair_ok = cpu_ok && bsp_ok && (s1_req_r.cpu_index != s1_req_r.bsp_index);
  assign aps_ok  = {1'b0, s1_req_r.ap_count} < active_r;

  // Request decode and outcome. The state moves only when stage 1 retires.
  always_comb begin
    arrival_nxt  = arrival_r;
    locked_nxt   = locked_r;
    cal_nxt      = cal_r;
    ram_we       = 1'b0;
    ram_waddr    = s1_addr;
    ram_wdata    = sem_cur;
    out_data_nxt = '{status: ST_OK, count: 8'd0};

    unique case (s1_req_r.req_type)
      REQ_CHECK_IN, REQ_CHECK_OUT: begin
        if (!cpu_ok) begin
          out_data_nxt.status = ST_BADIDX;
        end else if (locked_r) begin
          out_data_nxt = '{status: ST_ABORTED, count: {1'b0, cal_r}};
        end else if (s1_req_r.req_type == REQ_CHECK_IN) begin
          if (arrival_r == ARRIVAL_MAX) begin
            out_data_nxt = '{status: ST_SAT, count: {1'b0, arrival_r}};
          end else begin
            arrival_nxt        = arrival_r + 7'd1;
            out_data_nxt.count = {1'b0, arrival_nxt};
          end
        end else begin
          if (arrival_r == 7'd0) begin
            out_data_nxt.status = ST_BLOCK;
          end else begin
            arrival_nxt        = arrival_r - 7'd1;
            out_data_nxt.count = {1'b0, arrival_nxt};
          end
        end
      end
      REQ_LOCK_DOOR: begin
        if (!cpu_ok) begin
          out_data_nxt.status = ST_BADIDX;
        end else if (locked_r) begin
          // A second lock keeps the count recorded by the first.
          out_data_nxt = '{status: ST_ABORTED, count: {1'b0, cal_r}};
        end else begin
          cal_nxt            = arrival_r;
          locked_nxt         = 1'b1;
          out_data_nxt.count = {1'b0, arrival_r};
        end
      end
      REQ_GET_COUNT: begin
        out_data_nxt.count = locked_r ? {1'b0, cal_r} : {1'b0, arrival_r};
      end
      REQ_RESET: begin
        arrival_nxt = 7'd0;
        locked_nxt  = 1'b0;
        cal_nxt     = 7'd0;
      end
      REQ_RELEASE_AP, REQ_RELEASE_BSP: begin
        if (!pair_ok) begin
          out_data_nxt.status = ST_BADIDX;
        end else if (sem_cur == SEM_MAX) begin
          out_data_nxt = '{status: ST_SAT, count: SEM_MAX};
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = sem_cur + 8'd1;
          out_data_nxt.count = ram_wdata;
        end
      end
      REQ_AP_WAIT: begin
        if (!pair_ok) begin
          out_data_nxt.status = ST_BADIDX;
        end else if (sem_cur == 8'd0) begin
          out_data_nxt.status = ST_BLOCK;
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = sem_cur - 8'd1;
          out_data_nxt.count = ram_wdata;
        end
      end
      REQ_BSP_WAIT: begin
        if (!bsp_ok || !aps_ok) begin
          out_data_nxt.status = ST_BADIDX;
        end else if (sem_cur < {2'b00, s1_req_r.ap_count}) begin
          out_data_nxt = '{status: ST_BLOCK, count: sem_cur};
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = sem_cur - {2'b00, s1_req_r.ap_count};
          out_data_nxt.count = ram_wdata;
        end
      end
      default: begin
        // Unknown requests change nothing and report ok with a zero count.
        out_data_nxt = '{status: ST_OK, count: 8'd0};
      end
    endcase

    if (!s1_fire) begin
      arrival_nxt = arrival_r;
      locked_nxt  = locked_r;
      cal_nxt     = cal_r;
      ram_we      = 1'b0;
    end
  end

  assign s1_vld_nxt  = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s1_fire ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_CPUS_RST;
      arrival_r <= 7'd0;
      locked_r  <= 1'b0;
      cal_r     <= 7'd0;
      sem_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      arrival_r <= arrival_nxt;
      locked_r  <= locked_nxt;
      cal_r     <= cal_nxt;
      if (ram_we) begin
        sem_vld_r[ram_waddr] <= 1'b1;
      end
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r      <= in_data;
      s1_fwd_r      <= ram_we && (ram_waddr == ram_raddr);
      s1_fwd_data_r <= ram_wdata;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // The semaphore RAM is written only by a retiring request.
  a_ram_we_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> s1_fire)
    else $error("semaphore write without a retiring request");

  // The input side is stalled only while stage 1 holds a request.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with stage 1 empty");

  // Once locked, the door opens only through a reset request.
  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r && !(s1_fire && s1_req_r.req_type == REQ_RESET) |=> locked_r)
    else $error("door lock lost without a reset request");

  // A first lock records the arrival count of that moment.
  a_lock_records: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_req_r.req_type == REQ_LOCK_DOOR && cpu_ok && !locked_r
    |=> locked_r && cal_r == $past(arrival_r))
    else $error("lock did not record the arrival count");

  // A rejected index always reports a zero count.
  a_badidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.status == ST_BADIDX |-> out_data_r.count == 8'd0)
    else $error("bad index result with a non-zero count");

endmodule
